FILE: rtl/fspid_pkg.sv
// Shared constants, codes and types for the fan speed PID block.
package fspid_pkg;

   localparam int COUNT_BITS = 16;
   localparam int SPEED_W    = 22;
   localparam int DUTY_W     = 11;
   localparam int ERR_W      = 23;
   localparam int GAIN_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;

   localparam int SPEED_SCALE = 50;
   localparam int SCALE_W     = 6;
   localparam int PROD_RAW_W  = COUNT_BITS + SCALE_W;
   localparam int PROD_W      = (PROD_RAW_W > SPEED_W) ? PROD_RAW_W : SPEED_W + 1;
   localparam int SPEED_MAX   = (1 << SPEED_W) - 1;
   localparam int DUTY_MAX    = 2000;

   typedef enum logic [1:0] {
      ACT_PULSE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET = 2'd0,
      CSR_PROP   = 2'd1,
      CSR_INTEG  = 2'd2,
      CSR_DERIV  = 2'd3
   } csr_index_type;

   // Measurement stage result handed to the duty update
   typedef struct packed {
      logic                    tick;
      logic                    clear;
      logic                    fan_on;
      logic [SPEED_W-1:0]      speed;
      logic signed [ERR_W-1:0] e0;
      logic signed [ERR_W-1:0] e1;
      logic signed [ERR_W-1:0] e2;
   } meas_type;

endpackage

FILE: rtl/fspid_req_if.sv
// Input item channel: action code and fan enable.
interface fspid_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       fan_on;

   modport source (output valid, output action, output fan_on, input ready);
   modport sink (input valid, input action, input fan_on, output ready);
endinterface

FILE: rtl/fspid_rsp_if.sv
// Result item channel: measured speed, duty and update flag.
interface fspid_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fspid_pkg::SPEED_W-1:0]  speed;
   logic [fspid_pkg::DUTY_W-1:0]   duty;
   logic                           pid_ran;

   modport source (output valid, output speed, output duty, output pid_ran, input ready);
   modport sink (input valid, input speed, input duty, input pid_ran, output ready);
endinterface

FILE: rtl/fspid_meas.sv
// Pulse counter, speed measurement and error history stage.
module fspid_meas (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [1:0]                       action,
   input  logic                             fan_on,
   input  logic [fspid_pkg::SPEED_W-1:0]    target,
   output fspid_pkg::meas_type              meas
);

   logic [fspid_pkg::COUNT_BITS-1:0] cnt_ff;
   logic [fspid_pkg::COUNT_BITS-1:0] last_ff;
   logic signed [fspid_pkg::ERR_W-1:0] hist0_ff;
   logic signed [fspid_pkg::ERR_W-1:0] hist1_ff;
   fspid_pkg::meas_type meas_ff;
   fspid_pkg::meas_type meas_in;

   logic [fspid_pkg::COUNT_BITS-1:0] diff;
   logic [fspid_pkg::PROD_W-1:0]     prod;
   logic [fspid_pkg::SPEED_W-1:0]    speed;
   logic signed [fspid_pkg::ERR_W-1:0] err;
   fspid_pkg::action_type act;

   assign act  = fspid_pkg::action_type'(action);
   assign diff = cnt_ff - last_ff;
   assign prod = fspid_pkg::PROD_W'(diff) * fspid_pkg::PROD_W'(fspid_pkg::SPEED_SCALE);
   // saturate, only reachable with a counter wider than 16 bits
   assign speed = (prod > fspid_pkg::PROD_W'(fspid_pkg::SPEED_MAX)) ?
                  fspid_pkg::SPEED_W'(fspid_pkg::SPEED_MAX) : prod[fspid_pkg::SPEED_W-1:0];
   assign err = $signed({1'b0, speed}) - $signed({1'b0, target});

   always_comb begin
      meas_in.tick   = (act == fspid_pkg::ACT_TICK);
      meas_in.clear  = (act == fspid_pkg::ACT_CLEAR);
      meas_in.fan_on = fan_on;
      meas_in.speed  = speed;
      meas_in.e0     = err;
      meas_in.e1     = hist0_ff;
      meas_in.e2     = hist1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         last_ff  <= '0;
         hist0_ff <= '0;
         hist1_ff <= '0;
      end else if (go) begin
         unique case (act)
            fspid_pkg::ACT_PULSE: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            fspid_pkg::ACT_TICK: begin
               last_ff <= cnt_ff;
               if (fan_on) begin
                  hist0_ff <= err;
                  hist1_ff <= hist0_ff;
               end
            end
            fspid_pkg::ACT_CLEAR: begin
               cnt_ff   <= '0;
               last_ff  <= '0;
               hist0_ff <= '0;
               hist1_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         meas_ff <= meas_in;
      end
   end

   assign meas = meas_ff;

endmodule

FILE: rtl/fspid_duty.sv
// Incremental PID step and duty clamp.
module fspid_duty (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  fspid_pkg::meas_type               meas,
   input  logic [fspid_pkg::GAIN_W-1:0]      gain_prop,
   input  logic [fspid_pkg::GAIN_W-1:0]      gain_integ,
   input  logic [fspid_pkg::GAIN_W-1:0]      gain_deriv,
   output logic [fspid_pkg::DUTY_W-1:0]      duty_next
);

   localparam int D1_W  = fspid_pkg::ERR_W + 1;
   localparam int D2_W  = fspid_pkg::ERR_W + 3;
   localparam int G_W   = fspid_pkg::GAIN_W + 1;
   localparam int TP_W  = D1_W + G_W;
   localparam int TI_W  = fspid_pkg::ERR_W + G_W;
   localparam int TD_W  = D2_W + G_W;
   localparam int SUM_W = TD_W + 2;
   localparam int NV_W  = SUM_W + 1;

   logic [fspid_pkg::DUTY_W-1:0] duty_ff;
   logic [fspid_pkg::DUTY_W-1:0] duty_in;

   logic signed [D1_W-1:0]  d01;
   logic signed [D2_W-1:0]  d012;
   logic signed [TP_W-1:0]  tp;
   logic signed [TI_W-1:0]  ti;
   logic signed [TD_W-1:0]  td;
   logic signed [SUM_W-1:0] delta;
   logic signed [NV_W-1:0]  nv;
   logic [fspid_pkg::DUTY_W-1:0] clamped;

   assign d01  = D1_W'(meas.e0) - D1_W'(meas.e1);
   assign d012 = D2_W'(meas.e0) + D2_W'(meas.e2) - (D2_W'(meas.e1) <<< 1);
   assign tp   = TP_W'(d01) * TP_W'($signed({1'b0, gain_prop}));
   assign ti   = TI_W'(meas.e0) * TI_W'($signed({1'b0, gain_integ}));
   assign td   = TD_W'(d012) * TD_W'($signed({1'b0, gain_deriv}));
   assign delta = SUM_W'(tp) + SUM_W'(ti) + SUM_W'(td);
   assign nv   = $signed({{(NV_W-fspid_pkg::DUTY_W){1'b0}}, duty_ff}) - NV_W'(delta);

   always_comb begin
      priority if (nv < 0) begin
         clamped = '0;
      end else if (nv > NV_W'(fspid_pkg::DUTY_MAX)) begin
         clamped = fspid_pkg::DUTY_W'(fspid_pkg::DUTY_MAX);
      end else begin
         clamped = nv[fspid_pkg::DUTY_W-1:0];
      end
   end

   always_comb begin
      priority if (meas.clear) begin
         duty_in = '0;
      end else if (meas.tick && meas.fan_on) begin
         duty_in = clamped;
      end else begin
         duty_in = duty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else if (go) begin
         duty_ff <= duty_in;
      end
   end

   assign duty_next = duty_in;

endmodule

FILE: rtl/fan_speed_incremental_pid.sv
// Top level of the fan speed regulator with incremental PID duty control.
//
//  channel   direction  payload                       accepted when
//  req_ch    in         action, fan_on                valid & ready
//  rsp_ch    out        speed, duty, pid_ran          valid & ready
//  csr_*     in         index, data (22 bits)         csr_wr_en
//
// One item per cycle unless a tick waits for the output register. An item
// passes the input register, the measurement stage and the duty stage.
// Pulses and clears leave no result and need no room on rsp_ch,
// but they queue behind a tick that waits for the output register.
// Stages with a bubble keep accepting while a result waits in the output register.
// Synchronous reset clears all counters, history, duty, gains and target.
module fan_speed_incremental_pid (
   input  logic                               clock,
   input  logic                               reset,
   fspid_req_if.sink                          req_ch,
   fspid_rsp_if.source                        rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [fspid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fspid_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [fspid_pkg::SPEED_W-1:0] target_ff;
   logic [fspid_pkg::GAIN_W-1:0]  gain_prop_ff;
   logic [fspid_pkg::GAIN_W-1:0]  gain_integ_ff;
   logic [fspid_pkg::GAIN_W-1:0]  gain_deriv_ff;

   logic       a_valid_ff;
   logic [1:0] a_action_ff;
   logic       a_fan_ff;
   logic       b_valid_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [fspid_pkg::SPEED_W-1:0] rsp_speed_ff;
   logic [fspid_pkg::DUTY_W-1:0]  rsp_duty_ff;
   logic                          rsp_ran_ff;

   fspid_pkg::meas_type meas;
   logic [fspid_pkg::DUTY_W-1:0] duty_next;

   logic out_free;
   logic b_go;
   logic b_ready;
   logic a_go;
   logic a_ready;
   logic emit;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   // non-tick items retire at the duty stage without needing the output
   assign b_go     = b_valid_ff && (!meas.tick || out_free);
   assign b_ready  = !b_valid_ff || b_go;
   assign a_go     = a_valid_ff && b_ready;
   assign a_ready  = !a_valid_ff || a_go;
   assign emit     = b_go && meas.tick;

   assign req_ch.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (fspid_pkg::csr_index_type'(csr_index))
            fspid_pkg::CSR_TARGET: target_ff     <= csr_data[fspid_pkg::SPEED_W-1:0];
            fspid_pkg::CSR_PROP:   gain_prop_ff  <= csr_data[fspid_pkg::GAIN_W-1:0];
            fspid_pkg::CSR_INTEG:  gain_integ_ff <= csr_data[fspid_pkg::GAIN_W-1:0];
            fspid_pkg::CSR_DERIV:  gain_deriv_ff <= csr_data[fspid_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_ch.valid) begin
         a_action_ff <= req_ch.action;
         a_fan_ff    <= req_ch.fan_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   fspid_meas u_meas (
      .clock  (clock),
      .reset  (reset),
      .go     (a_go),
      .action (a_action_ff),
      .fan_on (a_fan_ff),
      .target (target_ff),
      .meas   (meas)
   );

   fspid_duty u_duty (
      .clock      (clock),
      .reset      (reset),
      .go         (b_go),
      .meas       (meas),
      .gain_prop  (gain_prop_ff),
      .gain_integ (gain_integ_ff),
      .gain_deriv (gain_deriv_ff),
      .duty_next  (duty_next)
   );

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_speed_ff <= meas.speed;
         rsp_duty_ff  <= duty_next;
         rsp_ran_ff   <= meas.fan_on;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.speed   = rsp_speed_ff;
   assign rsp_ch.duty    = rsp_duty_ff;
   assign rsp_ch.pid_ran = rsp_ran_ff;

endmodule

FILE: rtl/fspid_checker.sv
// Port-level checks for the fan speed regulator, bound to the top level.
module fspid_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [fspid_pkg::SPEED_W-1:0]   rsp_speed,
   input  logic [fspid_pkg::DUTY_W-1:0]    rsp_duty,
   input  logic                            rsp_pid_ran
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed) &&
      $stable(rsp_duty) && $stable(rsp_pid_ran))
      else $error("result changed while stalled");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= fspid_pkg::DUTY_W'(fspid_pkg::DUTY_MAX))
      else $error("duty above limit");

   // an empty output register lets every stage advance
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with output empty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fan_speed_incremental_pid fspid_checker u_fspid_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_speed   (rsp_ch.speed),
   .rsp_duty    (rsp_ch.duty),
   .rsp_pid_ran (rsp_ch.pid_ran)
);
